[rtl/tcc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package tcc_pkg;

	localparam int IN_W        = 16;
	localparam int COORD_WIDTH = 16;
	localparam int QUOT_W      = 32;

	// Exact integer widths of the circumcenter terms
	localparam int DIFF_W  = COORD_WIDTH + 1;
	localparam int PROD_W  = 2 * DIFF_W;
	localparam int D_W     = PROD_W + 1;
	localparam int NPROD_W = D_W + DIFF_W;
	localparam int NUM_W   = NPROD_W + 1;
	localparam int DEN_W   = D_W + 1;

	localparam int PREP_STAGES = 6;
	localparam int LATENCY     = PREP_STAGES + QUOT_W + 1;

	localparam logic signed [QUOT_W-1:0] OUT_MAX = {1'b0, {(QUOT_W-1){1'b1}}};
	localparam logic signed [QUOT_W-1:0] OUT_MIN = {1'b1, {(QUOT_W-1){1'b0}}};

	typedef enum logic [1:0] {
		ST_VALID     = 2'd0,
		ST_COLLINEAR = 2'd1,
		ST_SATURATED = 2'd2
	} tcc_status_t;

	// One word moving along the divider chain: both quotients share the divisor
	typedef struct packed {
		logic              zero;
		logic              ovf_x;
		logic              ovf_y;
		logic              neg_x;
		logic              neg_y;
		logic [DEN_W-1:0]  den;
		logic [DEN_W-1:0]  rem_x;
		logic [DEN_W-1:0]  rem_y;
		logic [QUOT_W-1:0] num_x;
		logic [QUOT_W-1:0] num_y;
		logic [QUOT_W-1:0] q_x;
		logic [QUOT_W-1:0] q_y;
	} tcc_div_t;

endpackage

`default_nettype wire

[rtl/tcc_prep.sv]
`timescale 1ns / 1ps
`default_nettype none

module tcc_prep (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_vld,
	input  wire logic signed [tcc_pkg::IN_W-1:0]   ax,
	input  wire logic signed [tcc_pkg::IN_W-1:0]   ay,
	input  wire logic signed [tcc_pkg::IN_W-1:0]   bx,
	input  wire logic signed [tcc_pkg::IN_W-1:0]   by,
	input  wire logic signed [tcc_pkg::IN_W-1:0]   qx,
	input  wire logic signed [tcc_pkg::IN_W-1:0]   qy,
	output logic                                   out_vld,
	output tcc_pkg::tcc_div_t                      out_word
);
	import tcc_pkg::*;

	logic [PREP_STAGES-1:0] vld_q;

	logic signed [COORD_WIDTH-1:0] cax, cay, cbx, cby, cqx, cqy;

	logic signed [DIFF_W-1:0]  ux_s1, uy_s1, vx_s1, vy_s1;
	logic signed [DIFF_W-1:0]  sax_s1, say_s1, sbx_s1, sby_s1;

	logic signed [PROD_W-1:0]  m_uv_s2, m_vu_s2, m_pa1_s2, m_pa2_s2, m_pb1_s2, m_pb2_s2;
	logic signed [DIFF_W-1:0]  ux_s2, uy_s2, vx_s2, vy_s2;

	logic signed [D_W-1:0]     d_s3, pa_s3, pb_s3;
	logic signed [DIFF_W-1:0]  ux_s3, uy_s3, vx_s3, vy_s3;

	logic signed [NPROD_W-1:0] n1_s4, n2_s4, n3_s4, n4_s4;
	logic signed [D_W-1:0]     d_s4;

	logic signed [NUM_W-1:0]   numx_s5, numy_s5;
	logic signed [DEN_W-1:0]   den_s5;
	logic                      zero_s5;

	logic [NUM_W-1:0] magx, magy, topx, topy, denm_ext;
	logic [DEN_W-1:0] denm;
	tcc_div_t         word_s6;

	function automatic tcc_div_t out_word_next();
		tcc_div_t w;
		w.zero  = zero_s5;
		w.ovf_x = (topx >= denm_ext);
		w.ovf_y = (topy >= denm_ext);
		w.neg_x = numx_s5[NUM_W-1] ^ den_s5[DEN_W-1];
		w.neg_y = numy_s5[NUM_W-1] ^ den_s5[DEN_W-1];
		w.den   = denm;
		w.rem_x = DEN_W'(topx);
		w.rem_y = DEN_W'(topy);
		w.num_x = QUOT_W'(magx);
		w.num_y = QUOT_W'(magy);
		w.q_x   = '0;
		w.q_y   = '0;
		return w;
	endfunction

	assign cax = ax[COORD_WIDTH-1:0];
	assign cay = ay[COORD_WIDTH-1:0];
	assign cbx = bx[COORD_WIDTH-1:0];
	assign cby = by[COORD_WIDTH-1:0];
	assign cqx = qx[COORD_WIDTH-1:0];
	assign cqy = qy[COORD_WIDTH-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[PREP_STAGES-2:0], in_vld};
		end
	end

	always_ff @(posedge clk) begin
		// differences to the third point and sums for the power terms
		ux_s1  <= DIFF_W'(cax) - DIFF_W'(cqx);
		uy_s1  <= DIFF_W'(cay) - DIFF_W'(cqy);
		vx_s1  <= DIFF_W'(cbx) - DIFF_W'(cqx);
		vy_s1  <= DIFF_W'(cby) - DIFF_W'(cqy);
		sax_s1 <= DIFF_W'(cax) + DIFF_W'(cqx);
		say_s1 <= DIFF_W'(cay) + DIFF_W'(cqy);
		sbx_s1 <= DIFF_W'(cbx) + DIFF_W'(cqx);
		sby_s1 <= DIFF_W'(cby) + DIFF_W'(cqy);

		m_uv_s2  <= PROD_W'(ux_s1) * PROD_W'(vy_s1);
		m_vu_s2  <= PROD_W'(vx_s1) * PROD_W'(uy_s1);
		m_pa1_s2 <= PROD_W'(ux_s1) * PROD_W'(sax_s1);
		m_pa2_s2 <= PROD_W'(uy_s1) * PROD_W'(say_s1);
		m_pb1_s2 <= PROD_W'(vx_s1) * PROD_W'(sbx_s1);
		m_pb2_s2 <= PROD_W'(vy_s1) * PROD_W'(sby_s1);
		ux_s2    <= ux_s1;
		uy_s2    <= uy_s1;
		vx_s2    <= vx_s1;
		vy_s2    <= vy_s1;

		d_s3  <= D_W'(m_uv_s2) - D_W'(m_vu_s2);
		pa_s3 <= D_W'(m_pa1_s2) + D_W'(m_pa2_s2);
		pb_s3 <= D_W'(m_pb1_s2) + D_W'(m_pb2_s2);
		ux_s3 <= ux_s2;
		uy_s3 <= uy_s2;
		vx_s3 <= vx_s2;
		vy_s3 <= vy_s2;

		n1_s4 <= NPROD_W'(pa_s3) * NPROD_W'(vy_s3);
		n2_s4 <= NPROD_W'(pb_s3) * NPROD_W'(uy_s3);
		n3_s4 <= NPROD_W'(pb_s3) * NPROD_W'(ux_s3);
		n4_s4 <= NPROD_W'(pa_s3) * NPROD_W'(vx_s3);
		d_s4  <= d_s3;

		numx_s5 <= NUM_W'(n1_s4) - NUM_W'(n2_s4);
		numy_s5 <= NUM_W'(n3_s4) - NUM_W'(n4_s4);
		den_s5  <= DEN_W'(d_s4) <<< 1;
		zero_s5 <= (d_s4 == '0);

		word_s6 <= out_word_next();
	end

	// magnitudes; the quotient fits 32 bits only when the high part is below the divisor
	assign magx     = numx_s5[NUM_W-1] ? NUM_W'(-numx_s5) : NUM_W'(numx_s5);
	assign magy     = numy_s5[NUM_W-1] ? NUM_W'(-numy_s5) : NUM_W'(numy_s5);
	assign denm     = den_s5[DEN_W-1] ? DEN_W'(-den_s5) : DEN_W'(den_s5);
	assign topx     = magx >> QUOT_W;
	assign topy     = magy >> QUOT_W;
	assign denm_ext = NUM_W'(denm);

	assign out_vld  = vld_q[PREP_STAGES-1];
	assign out_word = word_s6;

endmodule

`default_nettype wire

[rtl/tcc_div_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

module tcc_div_cell (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   in_vld,
	input  wire tcc_pkg::tcc_div_t in_word,
	output logic        out_vld,
	output tcc_pkg::tcc_div_t out_word
);
	import tcc_pkg::*;

	logic [DEN_W:0] trial_x, trial_y, den_ext;
	logic           take_x, take_y;
	tcc_div_t       nxt;
	tcc_div_t       word_q;
	logic           vld_q;

	// one restoring step per lane: bring down the next numerator bit, subtract if it fits
	always_comb begin
		den_ext = {1'b0, in_word.den};
		trial_x = {in_word.rem_x, in_word.num_x[QUOT_W-1]};
		trial_y = {in_word.rem_y, in_word.num_y[QUOT_W-1]};
		take_x  = (trial_x >= den_ext);
		take_y  = (trial_y >= den_ext);

		nxt       = in_word;
		nxt.rem_x = take_x ? DEN_W'(trial_x - den_ext) : DEN_W'(trial_x);
		nxt.rem_y = take_y ? DEN_W'(trial_y - den_ext) : DEN_W'(trial_y);
		nxt.num_x = in_word.num_x << 1;
		nxt.num_y = in_word.num_y << 1;
		nxt.q_x   = {in_word.q_x[QUOT_W-2:0], take_x};
		nxt.q_y   = {in_word.q_y[QUOT_W-2:0], take_y};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		word_q <= nxt;
	end

	assign out_vld  = vld_q;
	assign out_word = word_q;

endmodule

`default_nettype wire

[rtl/triangle_circumcenter_core.sv]
// Circumcenter of three points in the plane.
//
// Input channel: the six coordinates ax, ay, bx, by, qx, qy are taken at a
// rising edge with start high and busy low. busy stays low: a new point
// triple may be issued in every cycle.
// Result channel: done is high for exactly one cycle while center_x,
// center_y and status hold the result. The receiver cannot hold results
// off; results come out in issue order, one per accepted triple.
// Pipeline: 39 registers lie between the accepting edge and the result: the
// preparation's difference, product, numerator and magnitude
// stages, then a row of 32 divider cells (one quotient bit each for both
// coordinates), then the saturation and output register. Throughput is
// one triple per cycle.
// status: 0 valid, 1 collinear (centers are zero), 2 a coordinate
// saturated to the 32-bit range.
// Reset (arst_n low) empties the pipeline; in-flight triples are dropped
// and done stays low until a new triple has passed through.
`timescale 1ns / 1ps
`default_nettype none

module triangle_circumcenter_core (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	output logic                                   busy,
	input  wire logic signed [tcc_pkg::IN_W-1:0]   ax,
	input  wire logic signed [tcc_pkg::IN_W-1:0]   ay,
	input  wire logic signed [tcc_pkg::IN_W-1:0]   bx,
	input  wire logic signed [tcc_pkg::IN_W-1:0]   by,
	input  wire logic signed [tcc_pkg::IN_W-1:0]   qx,
	input  wire logic signed [tcc_pkg::IN_W-1:0]   qy,
	output logic                                   done,
	output logic signed [tcc_pkg::QUOT_W-1:0]      center_x,
	output logic signed [tcc_pkg::QUOT_W-1:0]      center_y,
	output tcc_pkg::tcc_status_t                   status
);
	import tcc_pkg::*;

	logic     chain_vld [0:QUOT_W];
	tcc_div_t chain_word [0:QUOT_W];

	tcc_div_t fin;
	logic     clamp_x, clamp_y;
	logic signed [QUOT_W-1:0] val_x, val_y;

	logic                     done_q;
	logic signed [QUOT_W-1:0] center_x_q, center_y_q;
	tcc_status_t              status_q;

	assign busy = 1'b0;

	tcc_prep u_prep (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (start && !busy),
		.ax       (ax),
		.ay       (ay),
		.bx       (bx),
		.by       (by),
		.qx       (qx),
		.qy       (qy),
		.out_vld  (chain_vld[0]),
		.out_word (chain_word[0])
	);

	for (genvar i = 0; i < QUOT_W; i++) begin : g_cell
		tcc_div_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_vld   (chain_vld[i]),
			.in_word  (chain_word[i]),
			.out_vld  (chain_vld[i+1]),
			.out_word (chain_word[i+1])
		);
	end

	assign fin = chain_word[QUOT_W];

	// a negative quotient may reach one past the positive limit
	always_comb begin
		clamp_x = fin.ovf_x || (fin.neg_x ? (fin.q_x[QUOT_W-1] && |fin.q_x[QUOT_W-2:0])
		                                  : fin.q_x[QUOT_W-1]);
		clamp_y = fin.ovf_y || (fin.neg_y ? (fin.q_y[QUOT_W-1] && |fin.q_y[QUOT_W-2:0])
		                                  : fin.q_y[QUOT_W-1]);
		if (clamp_x) begin
			val_x = fin.neg_x ? OUT_MIN : OUT_MAX;
		end else begin
			val_x = fin.neg_x ? -$signed(fin.q_x) : $signed(fin.q_x);
		end
		if (clamp_y) begin
			val_y = fin.neg_y ? OUT_MIN : OUT_MAX;
		end else begin
			val_y = fin.neg_y ? -$signed(fin.q_y) : $signed(fin.q_y);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= chain_vld[QUOT_W];
		end
	end

	always_ff @(posedge clk) begin
		if (fin.zero) begin
			center_x_q <= '0;
			center_y_q <= '0;
			status_q   <= ST_COLLINEAR;
		end else begin
			center_x_q <= val_x;
			center_y_q <= val_y;
			status_q   <= (clamp_x || clamp_y) ? ST_SATURATED : ST_VALID;
		end
	end

	assign done     = done_q;
	assign center_x = center_x_q;
	assign center_y = center_y_q;
	assign status   = status_q;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LATENCY done)
		else $error("accepted word did not come out after the pipeline latency");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result word without a matching accepted word");

	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == ST_SATURATED |->
			center_x == OUT_MAX || center_x == OUT_MIN ||
			center_y == OUT_MAX || center_y == OUT_MIN)
		else $error("saturated status without a clamped coordinate");

endmodule

`default_nettype wire

[tb/triangle_circumcenter_core_tb.sv]
`timescale 1ns / 1ps

module triangle_circumcenter_core_tb;
	import tcc_pkg::*;

	typedef struct {
		logic signed [QUOT_W-1:0] cx;
		logic signed [QUOT_W-1:0] cy;
		tcc_status_t              st;
	} center_t;

	class center_board;
		center_t awaited_q[$];
		int errors = 0;
		int n_valid = 0;
		int n_collinear = 0;
		int n_saturated = 0;

		// sign-extend a raw field from the active coordinate width
		function longint coord_val(logic [IN_W-1:0] raw);
			longint v;
			v = longint'(raw) & ((longint'(1) << COORD_WIDTH) - 1);
			if (((v >> (COORD_WIDTH - 1)) & 1) != 0)
				v = v - (longint'(1) << COORD_WIDTH);
			return v;
		endfunction

		function center_t circumcenter_of(logic [IN_W-1:0] rax, ray, rbx, rby, rqx, rqy);
			center_t c;
			longint pax, pay, pbx, pby, pqx, pqy;
			longint ux, uy, vx, vy, det, pa, pb, num_x, num_y, den, quo_x, quo_y;
			bit clamped;
			pax = coord_val(rax);
			pay = coord_val(ray);
			pbx = coord_val(rbx);
			pby = coord_val(rby);
			pqx = coord_val(rqx);
			pqy = coord_val(rqy);
			ux = pax - pqx;
			uy = pay - pqy;
			vx = pbx - pqx;
			vy = pby - pqy;
			det = ux * vy - vx * uy;
			if (det == 0) begin
				c.cx = '0;
				c.cy = '0;
				c.st = ST_COLLINEAR;
				return c;
			end
			pa = ux * (pax + pqx) + uy * (pay + pqy);
			pb = vx * (pbx + pqx) + vy * (pby + pqy);
			num_x = pa * vy - pb * uy;
			num_y = pb * ux - pa * vx;
			den = 2 * det;
			// signed longint division truncates toward zero
			quo_x = num_x / den;
			quo_y = num_y / den;
			clamped = 1'b0;
			if (quo_x > longint'(OUT_MAX)) begin
				quo_x = longint'(OUT_MAX);
				clamped = 1'b1;
			end else if (quo_x < longint'(OUT_MIN)) begin
				quo_x = longint'(OUT_MIN);
				clamped = 1'b1;
			end
			if (quo_y > longint'(OUT_MAX)) begin
				quo_y = longint'(OUT_MAX);
				clamped = 1'b1;
			end else if (quo_y < longint'(OUT_MIN)) begin
				quo_y = longint'(OUT_MIN);
				clamped = 1'b1;
			end
			c.cx = quo_x[QUOT_W-1:0];
			c.cy = quo_y[QUOT_W-1:0];
			c.st = clamped ? ST_SATURATED : ST_VALID;
			return c;
		endfunction

		function void note_triple(logic [IN_W-1:0] rax, ray, rbx, rby, rqx, rqy);
			center_t c;
			c = circumcenter_of(rax, ray, rbx, rby, rqx, rqy);
			case (c.st)
				ST_COLLINEAR: n_collinear++;
				ST_SATURATED: n_saturated++;
				default:      n_valid++;
			endcase
			awaited_q.insert(awaited_q.size(), c);
		endfunction

		function void check_center(logic signed [QUOT_W-1:0] cx, cy, tcc_status_t st);
			center_t e;
			if (awaited_q.size() == 0) begin
				$display("%0t: unexpected word cx=%0d cy=%0d status=%0d", $time, cx, cy, st);
				errors++;
				return;
			end
			e = awaited_q.pop_front();
			if (cx !== e.cx) begin
				$display("%0t: center_x expected %0d got %0d", $time, e.cx, cx);
				errors++;
			end
			if (cy !== e.cy) begin
				$display("%0t: center_y expected %0d got %0d", $time, e.cy, cy);
				errors++;
			end
			if (st !== e.st) begin
				$display("%0t: status expected %0d got %0d", $time, e.st, st);
				errors++;
			end
		endfunction

		function int pending();
			return awaited_q.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic signed [IN_W-1:0] ax = '0;
	logic signed [IN_W-1:0] ay = '0;
	logic signed [IN_W-1:0] bx = '0;
	logic signed [IN_W-1:0] by = '0;
	logic signed [IN_W-1:0] qx = '0;
	logic signed [IN_W-1:0] qy = '0;
	logic done;
	logic signed [QUOT_W-1:0] center_x;
	logic signed [QUOT_W-1:0] center_y;
	tcc_status_t status;

	center_board sb;

	// corners, collinear sets, unit determinants, truncation of both signs
	int corner_set [17][6] = '{
		'{0, 0, 0, 0, 0, 0},
		'{32767, 32767, 32767, 32767, 32767, 32767},
		'{-32768, -32768, -32768, -32768, -32768, -32768},
		'{32767, -32768, -32768, 32767, -32768, -32768},
		'{-32768, 32767, 32767, -32768, 32767, 32767},
		'{16, 0, 0, 16, 0, 0},
		'{160, 0, 0, 160, 0, 0},
		'{100, 0, 50, 87, 0, 0},
		'{10, 20, 30, 60, 0, 0},
		'{5, 7, 100, -3, 5, 7},
		'{32767, 32766, 32766, 32765, -32768, -32768},
		'{32766, 32765, 32767, 32766, -32768, -32768},
		'{-32768, -32767, -32767, -32766, 32767, 32767},
		'{-16, 0, 0, -16, 0, 0},
		'{3, 0, 0, 3, 0, 0},
		'{-3, 0, 0, -3, 0, 0},
		'{4, 1, 1, 5, 1, 1}
	};

	triangle_circumcenter_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.ax       (ax),
		.ay       (ay),
		.bx       (bx),
		.by       (by),
		.qx       (qx),
		.qy       (qy),
		.done     (done),
		.center_x (center_x),
		.center_y (center_y),
		.status   (status)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_center(center_x, center_y, status);
	end

	task automatic send_triple(input int a_x, a_y, b_x, b_y, q_x, q_y);
		@(negedge clk);
		start <= 1'b1;
		ax <= a_x[IN_W-1:0];
		ay <= a_y[IN_W-1:0];
		bx <= b_x[IN_W-1:0];
		by <= b_y[IN_W-1:0];
		qx <= q_x[IN_W-1:0];
		qy <= q_y[IN_W-1:0];
		do @(posedge clk); while (busy);
		sb.note_triple(a_x[IN_W-1:0], a_y[IN_W-1:0], b_x[IN_W-1:0], b_y[IN_W-1:0],
			q_x[IN_W-1:0], q_y[IN_W-1:0]);
	endtask

	task automatic rest(input int n);
		if (n > 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// hold off until every word in flight has come back
	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	initial begin
		int kind, n, sx, sy, base_x, base_y, dx, dy, t1, t2;
		int p [6];
		sb = new;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (corner_set[i]) begin
			send_triple(corner_set[i][0], corner_set[i][1], corner_set[i][2],
				corner_set[i][3], corner_set[i][4], corner_set[i][5]);
			rest(gap_len());
		end
		drain();

		for (int i = 0; i < 650; i++) begin
			if (i == 325)
				drain();
			kind = $urandom_range(0, 99);
			if (kind < 35) begin
				foreach (p[k]) p[k] = $urandom_range(0, 65535) - 32768;
			end else if (kind < 50) begin
				foreach (p[k]) p[k] = $urandom_range(0, 64) - 32;
			end else if (kind < 65) begin
				// points on one line, duplicates now and then
				base_x = $urandom_range(0, 32000) - 16000;
				base_y = $urandom_range(0, 32000) - 16000;
				dx = $urandom_range(0, 80) - 40;
				dy = $urandom_range(0, 80) - 40;
				t1 = $urandom_range(0, 600) - 300;
				t2 = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(0, 600) - 300;
				p = '{base_x + t1 * dx, base_y + t1 * dy, base_x + t2 * dx, base_y + t2 * dy,
					base_x, base_y};
			end else begin
				// nearly collinear with unit determinant: drives the saturation range
				n = $urandom_range(1, 32000);
				sx = $urandom_range(0, 1) ? 1 : -1;
				sy = $urandom_range(0, 1) ? 1 : -1;
				base_x = $urandom_range(0, 65535 - 2 * (n + 1)) - 32767 + n + 1;
				base_y = $urandom_range(0, 65535 - 2 * (n + 1)) - 32767 + n + 1;
				p = '{base_x + sx * (n + 1), base_y + sy * n, base_x + sx * n,
					base_y + sy * (n - 1), base_x, base_y};
				if ($urandom_range(0, 1))
					p = '{p[2], p[3], p[0], p[1], p[4], p[5]};
			end
			send_triple(p[0], p[1], p[2], p[3], p[4], p[5]);
			// back-to-back stretch in the last 40 words of every full block of 160 words
			if ((i % 160) < 120)
				rest(gap_len());
		end

		drain();
		repeat (LATENCY + 10) @(posedge clk);
		$display("Covered %0d triples: %0d valid, %0d collinear, %0d saturated",
			sb.n_valid + sb.n_collinear + sb.n_saturated, sb.n_valid, sb.n_collinear,
			sb.n_saturated);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("triangle_circumcenter_core test passed");
		else
			$display("triangle_circumcenter_core test failed");
		$finish;
	end

	initial begin
		#6000000;
		$display("triangle_circumcenter_core test failed");
		$finish;
	end

endmodule
